/* design/source_tokenizer_unit_assert.svh */
// assertion macros used by the source tokenizer back part
// no dependencies
`ifndef SOURCE_TOKENIZER_UNIT_ASSERT_SVH
`define SOURCE_TOKENIZER_UNIT_ASSERT_SVH
// implication checked at every rising clock edge outside reset
`define STU_ASSERT_IMP(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) else $error(msg);
// next-cycle implication outside reset
`define STU_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) else $error(msg);
`endif

/* design/stok_pkg.sv */
// shared types and constants of the source tokenizer
// no dependencies
`timescale 1ns / 1ps
package stok_pkg;
   localparam logic [3:0] M_IDLE    = 4'd0;
   localparam logic [3:0] M_BLANK   = 4'd1;
   localparam logic [3:0] M_SLASH   = 4'd2;
   localparam logic [3:0] M_COMMENT = 4'd3;
   localparam logic [3:0] M_NAME    = 4'd4;
   localparam logic [3:0] M_STRING  = 4'd5;
   localparam logic [3:0] M_ESC     = 4'd6;
   localparam logic [3:0] M_HEX1    = 4'd7;
   localparam logic [3:0] M_HEX2    = 4'd8;

   localparam logic [2:0] K_BLANK   = 3'd0;
   localparam logic [2:0] K_COMMENT = 3'd1;
   localparam logic [2:0] K_NEWLINE = 3'd2;
   localparam logic [2:0] K_NAME    = 3'd3;
   localparam logic [2:0] K_STRING  = 3'd4;
   localparam logic [2:0] K_END     = 3'd5;
   localparam logic [2:0] K_ERROR   = 3'd6;

   localparam logic [2:0] E_NONE    = 3'd0;
   localparam logic [2:0] E_INVALID = 3'd1;
   localparam logic [2:0] E_EOF_STR = 3'd2;
   localparam logic [2:0] E_EOL_STR = 3'd3;
   localparam logic [2:0] E_ESCAPE  = 3'd4;
   localparam logic [2:0] E_HEX     = 3'd5;

   localparam logic [0:0] REG_TAB_MODE = 1'd0;
   localparam logic [0:0] REG_UNESCAPE = 1'd1;

   localparam int MAX_RESULTS = 4;

   // one result before the line and column are attached
   typedef struct packed {
      logic [2:0] kind;
      logic       has;
      logic [7:0] val;
      logic       done;
      logic [2:0] err;
   } res_type;

   // classified item handed from front to back
   typedef struct packed {
      logic [2:0]  count;
      res_type [MAX_RESULTS-1:0] res;
      logic [1:0]  pos_sel;  // index of first result using the new token position
   } item_type;

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
   endfunction

   function automatic logic is_name_char(input logic [7:0] c);
      return is_letter(c) || c == 8'h5f || (c >= 8'h30 && c <= 8'h39);
   endfunction

   function automatic logic [4:0] nibble(input logic [7:0] c);
      logic [7:0] t;
      t = 8'd16;
      if (c >= 8'h30 && c <= 8'h39) t = c - 8'h30;
      else if (c >= 8'h61 && c <= 8'h66) t = c - 8'h57;
      else if (c >= 8'h41 && c <= 8'h46) t = c - 8'h37;
      return t[4:0];
   endfunction

   // bit 8 set when the escape is not known
   function automatic logic [8:0] decode_escape(input logic [7:0] c);
      logic [8:0] r;
      case (c)
         8'h30:   r = 9'd0;
         8'h61:   r = 9'd7;
         8'h62:   r = 9'd8;
         8'h66:   r = 9'd12;
         8'h6e:   r = 9'd10;
         8'h74:   r = 9'd9;
         8'h72:   r = 9'd13;
         8'h76:   r = 9'd11;
         8'h27:   r = 9'h27;
         8'h22:   r = 9'h22;
         8'h5c:   r = 9'h5c;
         default: r = 9'h100;
      endcase
      return r;
   endfunction
endpackage

/* design/stok_front.sv */
// front part: scanner state machine, classifies each byte into up to two results
// depends on stok_pkg
`timescale 1ns / 1ps
module stok_front #(
   parameter int LINE_BITS   = 20,
   parameter int COLUMN_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic [7:0]               char_byte,
   input  logic                     end_of_input,
   input  logic [4:0]               expected_mask,
   input  logic [1:0]               tab_mode,
   input  logic                     unescape,
   output logic                     q_valid,
   input  logic                     q_ready,
   output stok_pkg::item_type       q_item,
   output logic [LINE_BITS-1:0]     q_line0,
   output logic [COLUMN_BITS-1:0]   q_col0,
   output logic [LINE_BITS-1:0]     q_line1,
   output logic [COLUMN_BITS-1:0]   q_col1
);
   import stok_pkg::*;

   localparam logic [LINE_BITS-1:0]   LMAX = {LINE_BITS{1'b1}};
   localparam logic [COLUMN_BITS-1:0] CMAX = {COLUMN_BITS{1'b1}};

   logic [3:0]             mode_ff, mode_in;
   logic                   dq_ff, dq_in;
   logic [7:0]             hex_ff, hex_in;
   logic                   hbad_ff, hbad_in;
   logic [2:0]             serr_ff, serr_in;
   logic [LINE_BITS-1:0]   line_ff, line_in, tline_ff, tline_in;
   logic [COLUMN_BITS-1:0] col_ff, col_in, tcol_ff, tcol_in;
   logic [4:0]             held_ff, held_in;

   item_type it;
   logic     fire;
   logic     restart;
   logic     use_held;
   logic     ending;
   logic [4:0] smask;
   logic       all;
   logic [8:0] dec;
   logic [4:0] nib;
   logic [3:0] stop;
   logic [COLUMN_BITS:0] csum;
   logic [7:0] c;

   assign in_ready = q_ready;
   assign fire     = in_valid && in_ready;
   assign q_valid  = in_valid;
   assign q_item   = it;
   assign q_line0  = tline_ff;
   assign q_col0   = tcol_ff;
   assign q_line1  = tline_in;
   assign q_col1   = tcol_in;
   assign c        = char_byte;

   // classification of one byte
   always_comb begin
      it       = '0;
      mode_in  = mode_ff;
      dq_in    = dq_ff;
      hex_in   = hex_ff;
      hbad_in  = hbad_ff;
      serr_in  = serr_ff;
      line_in  = line_ff;
      col_in   = col_ff;
      tline_in = tline_ff;
      tcol_in  = tcol_ff;
      held_in  = held_ff;
      restart  = 1'b0;
      use_held = 1'b0;
      ending   = end_of_input || c == 8'h00;
      dec      = decode_escape(c);
      nib      = nibble(c);
      smask    = 5'd0;
      all      = 1'b0;
      stop     = 4'd4;
      csum     = '0;
      it.pos_sel = 2'd3;
      if (ending) begin
         unique case (mode_ff)
            M_BLANK:   it.res[0] = '{K_BLANK, 1'b0, 8'd0, 1'b1, E_NONE};
            M_COMMENT: it.res[0] = '{K_COMMENT, 1'b0, 8'd0, 1'b1, E_NONE};
            M_NAME:    it.res[0] = '{K_NAME, 1'b0, 8'd0, 1'b1, E_NONE};
            M_SLASH:   it.res[0] = '{K_ERROR, 1'b0, 8'd0, 1'b1, E_INVALID};
            M_STRING, M_ESC, M_HEX1, M_HEX2:
                       it.res[0] = '{K_STRING, 1'b0, 8'd0, 1'b1, E_EOF_STR};
            default:   it.res[0] = '0;
         endcase
         if (mode_ff == M_IDLE) begin
            it.res[0]  = '{K_END, 1'b0, 8'd0, 1'b1, E_NONE};
            it.count   = 3'd1;
            it.pos_sel = 2'd0;
         end else begin
            it.res[1]  = '{K_END, 1'b0, 8'd0, 1'b1, E_NONE};
            it.count   = 3'd2;
            it.pos_sel = 2'd1;
         end
         mode_in  = M_IDLE;
         serr_in  = E_NONE;
         tline_in = line_ff;
         tcol_in  = col_ff;
      end else begin
         unique case (mode_ff)
            M_BLANK: begin
               if (c == 8'h20 || c == 8'h09) begin
                  it.res[0] = '{K_BLANK, 1'b1, c, 1'b0, E_NONE};
                  it.count  = 3'd1;
               end else begin
                  it.res[0] = '{K_BLANK, 1'b0, 8'd0, 1'b1, E_NONE};
                  it.count  = 3'd1;
                  restart   = 1'b1;
               end
            end
            M_SLASH: begin
               if (c == 8'h2f) mode_in = M_COMMENT;
               else begin
                  it.res[0] = '{K_ERROR, 1'b0, 8'd0, 1'b1, E_INVALID};
                  it.count  = 3'd1;
                  restart   = 1'b1;
                  use_held  = 1'b1;
               end
            end
            M_COMMENT: begin
               if (c == 8'h0a) begin
                  it.res[0] = '{K_COMMENT, 1'b0, 8'd0, 1'b1, E_NONE};
                  restart   = 1'b1;
               end else it.res[0] = '{K_COMMENT, 1'b1, c, 1'b0, E_NONE};
               it.count = 3'd1;
            end
            M_NAME: begin
               if (is_name_char(c)) it.res[0] = '{K_NAME, 1'b1, c, 1'b0, E_NONE};
               else begin
                  it.res[0] = '{K_NAME, 1'b0, 8'd0, 1'b1, E_NONE};
                  restart   = 1'b1;
               end
               it.count = 3'd1;
            end
            M_STRING: begin
               if (c == (dq_ff ? 8'h22 : 8'h27)) begin
                  it.res[0] = '{K_STRING, 1'b0, 8'd0, 1'b1, serr_ff};
                  it.count  = 3'd1;
                  serr_in   = E_NONE;
                  mode_in   = M_IDLE;
               end else if (c == 8'h0a) begin
                  it.res[0] = '{K_STRING, 1'b0, 8'd0, 1'b1, E_EOL_STR};
                  it.count  = 3'd1;
                  restart   = 1'b1;
                  use_held  = 1'b1;
               end else if (c == 8'h5c) begin
                  mode_in = M_ESC;
               end else begin
                  it.res[0] = '{K_STRING, 1'b1, c, 1'b0, E_NONE};
                  it.count  = 3'd1;
               end
            end
            M_ESC: begin
               if (c == 8'h78) begin
                  mode_in = M_HEX1;
                  hex_in  = 8'd0;
                  hbad_in = 1'b0;
                  if (!unescape) begin
                     it.res[0] = '{K_STRING, 1'b1, 8'h5c, 1'b0, E_NONE};
                     it.res[1] = '{K_STRING, 1'b1, 8'h78, 1'b0, E_NONE};
                     it.count  = 3'd2;
                  end
               end else begin
                  mode_in = M_STRING;
                  if (!unescape) begin
                     it.res[0] = '{K_STRING, 1'b1, 8'h5c, 1'b0, E_NONE};
                     it.res[1] = '{K_STRING, 1'b1, c, 1'b0, E_NONE};
                     it.count  = 3'd2;
                  end else if (dec[8]) begin
                     if (serr_ff == E_NONE) serr_in = E_ESCAPE;
                  end else begin
                     it.res[0] = '{K_STRING, 1'b1, dec[7:0], 1'b0, E_NONE};
                     it.count  = 3'd1;
                  end
               end
            end
            M_HEX1: begin
               mode_in = M_HEX2;
               if (!unescape) begin
                  it.res[0] = '{K_STRING, 1'b1, c, 1'b0, E_NONE};
                  it.count  = 3'd1;
               end else if (nib[4]) hbad_in = 1'b1;
               else hex_in = {nib[3:0], 4'd0};
            end
            M_HEX2: begin
               mode_in = M_STRING;
               if (!unescape) begin
                  it.res[0] = '{K_STRING, 1'b1, c, 1'b0, E_NONE};
                  it.count  = 3'd1;
               end else begin
                  if (nib[4]) hbad_in = 1'b1;
                  else hex_in = hex_ff | {4'd0, nib[3:0]};
                  if (hbad_in) begin
                     if (serr_ff == E_NONE) serr_in = E_HEX;
                  end else begin
                     it.res[0] = '{K_STRING, 1'b1, hex_in, 1'b0, E_NONE};
                     it.count  = 3'd1;
                  end
               end
            end
            default: restart = 1'b1;
         endcase
         // token start on the same byte
         if (restart) begin
            smask    = use_held ? held_ff : expected_mask;
            all      = smask == 5'd0;
            tline_in = line_ff;
            tcol_in  = col_ff;
            held_in  = smask;
            serr_in  = E_NONE;
            mode_in  = M_IDLE;
            it.pos_sel = it.count[1:0];
            if ((c == 8'h20 || c == 8'h09) && (all || smask[0])) begin
               mode_in = M_BLANK;
               it.res[it.count[1:0]] = '{K_BLANK, 1'b1, c, 1'b0, E_NONE};
               it.count = it.count + 3'd1;
            end else if (c == 8'h2f && (all || smask[1])) begin
               mode_in = M_SLASH;
            end else if (c == 8'h0a && (all || smask[2])) begin
               it.res[it.count[1:0]] = '{K_NEWLINE, 1'b0, 8'd0, 1'b1, E_NONE};
               it.count = it.count + 3'd1;
            end else if ((is_letter(c) || c == 8'h5f) && (all || smask[3])) begin
               mode_in = M_NAME;
               it.res[it.count[1:0]] = '{K_NAME, 1'b1, c, 1'b0, E_NONE};
               it.count = it.count + 3'd1;
            end else if ((c == 8'h27 || c == 8'h22) && (all || smask[4])) begin
               mode_in = M_STRING;
               dq_in   = c == 8'h22;
            end else begin
               it.res[it.count[1:0]] = '{K_ERROR, 1'b0, 8'd0, 1'b1, E_INVALID};
               it.count = it.count + 3'd1;
            end
         end
         // position update
         if (c == 8'h0a) begin
            if (line_ff != LMAX) line_in = line_ff + 1'b1;
            col_in = {{(COLUMN_BITS-1){1'b0}}, 1'b1};
         end else if (c == 8'h0d) begin
            col_in = col_ff;
         end else if (c == 8'h09) begin
            stop = (tab_mode == 2'd0) ? 4'd2 : ((tab_mode == 2'd2) ? 4'd8 : 4'd4);
            csum = {1'b0, col_ff} + {{(COLUMN_BITS-3){1'b0}}, stop}
                 - {{(COLUMN_BITS-2){1'b0}}, ((col_ff[2:0] - 3'd1) & (stop[2:0] - 3'd1))};
            col_in = (csum > {1'b0, CMAX}) ? CMAX : csum[COLUMN_BITS-1:0];
         end else if (col_ff != CMAX) col_in = col_ff + 1'b1;
      end
   end

   // scanner state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= M_IDLE;
         dq_ff    <= 1'b0;
         hex_ff   <= 8'd0;
         hbad_ff  <= 1'b0;
         serr_ff  <= E_NONE;
         line_ff  <= {{(LINE_BITS-1){1'b0}}, 1'b1};
         col_ff   <= {{(COLUMN_BITS-1){1'b0}}, 1'b1};
         tline_ff <= {{(LINE_BITS-1){1'b0}}, 1'b1};
         tcol_ff  <= {{(COLUMN_BITS-1){1'b0}}, 1'b1};
         held_ff  <= 5'd0;
      end else if (fire) begin
         mode_ff  <= mode_in;
         dq_ff    <= dq_in;
         hex_ff   <= hex_in;
         hbad_ff  <= hbad_in;
         serr_ff  <= serr_in;
         line_ff  <= line_in;
         col_ff   <= col_in;
         tline_ff <= tline_in;
         tcol_ff  <= tcol_in;
         held_ff  <= held_in;
      end
   end
endmodule

/* design/stok_back.sv */
// back part: two-entry item queue and result sequencer
// depends on stok_pkg and the assertion macro header
`timescale 1ns / 1ps
module stok_back #(
   parameter int LINE_BITS   = 20,
   parameter int COLUMN_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   output logic                   q_ready,
   input  stok_pkg::item_type     q_item,
   input  logic [LINE_BITS-1:0]   q_line0,
   input  logic [COLUMN_BITS-1:0] q_col0,
   input  logic [LINE_BITS-1:0]   q_line1,
   input  logic [COLUMN_BITS-1:0] q_col1,
   output logic                   out_valid,
   input  logic                   out_ready,
   output stok_pkg::res_type      out_res,
   output logic [LINE_BITS-1:0]   out_line,
   output logic [COLUMN_BITS-1:0] out_col,
   output logic                   out_last
);
   import stok_pkg::*;
`include "source_tokenizer_unit_assert.svh"

   localparam int W = $bits(item_type) + 2 * (LINE_BITS + COLUMN_BITS);

   logic [W-1:0] mem_ff [2];
   logic [1:0]   cnt_ff, cnt_in;
   logic         wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]   idx_ff, idx_in;
   item_type     head;
   logic [LINE_BITS-1:0]   l0, l1;
   logic [COLUMN_BITS-1:0] c0, c1;
   logic push, pop, take, empty_item;

   assign {head, l0, c0, l1, c1} = mem_ff[rp_ff];
   assign q_ready    = cnt_ff != 2'd2;
   assign push       = q_valid && q_ready && q_item.count != 3'd0;
   assign empty_item = head.count == 3'd0;
   assign out_valid  = cnt_ff != 2'd0;
   assign out_res    = head.res[idx_ff];
   assign out_last   = {1'b0, idx_ff} == head.count - 3'd1;
   assign out_line   = (idx_ff >= head.pos_sel) ? l1 : l0;
   assign out_col    = (idx_ff >= head.pos_sel) ? c1 : c0;
   assign take       = out_valid && out_ready;
   assign pop        = take && out_last;

   // queue pointers and result index
   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
      idx_in = pop ? 2'd0 : (take ? idx_ff + 2'd1 : idx_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         idx_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         idx_ff <= idx_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= {q_item, q_line0, q_col0, q_line1, q_col1};
   end

   `STU_ASSERT_IMP(a_no_empty_head, clock, reset, out_valid, !empty_item, "empty item queued")
   `STU_ASSERT_IMP(a_idx_in_range, clock, reset, out_valid, {1'b0, idx_ff} < head.count, "index past count")
   `STU_ASSERT_NEXT(a_hold, clock, reset, out_valid && !out_ready, out_valid, "result dropped")
endmodule

/* design/source_tokenizer_unit.sv */
// top level of the source tokenizer: front scanner, queue and result sequencer
// depends on stok_pkg, stok_front and stok_back
//
//  port group | dir | payload
//  req_*      | in  | one source byte with end flag and kind mask
//  rsp_*      | out | one result (value byte or token end)
//  csr_*      | in  | register writes, no read-back
//
// one byte is taken per cycle while the queue has room; the scanner state
// register closes the only loop. each byte gives zero to two results, one per
// cycle while rsp_tready is high, from a two-entry queue that holds the input
// when full. reset is synchronous and clears scanner, counters and queue.
`timescale 1ns / 1ps
module source_tokenizer_unit #(
   parameter int LINE_BITS   = 20,
   parameter int COLUMN_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // char_byte
   input  logic [5:0]  req_tuser,  // end_of_input, expected_mask[4:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // has_value_byte, value_byte, token_done, error_code, start_line, start_column
   output logic [((LINE_BITS+COLUMN_BITS+13+7)/8)*8-1:0] rsp_tdata,
   output logic [2:0]  rsp_tuser,  // token_kind
   output logic        rsp_tlast,  // last
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [1:0]  csr_wdata
);
   import stok_pkg::*;

   localparam int PW = 13 + LINE_BITS + COLUMN_BITS;
   localparam int DW = ((PW + 7) / 8) * 8;

   logic [1:0] tab_ff;
   logic       unesc_ff;
   logic       q_valid, q_ready;
   item_type   q_item;
   logic [LINE_BITS-1:0]   l0, l1, oline;
   logic [COLUMN_BITS-1:0] c0, c1, ocol;
   res_type    ores;
   logic [DW-1:0] packed_d;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tab_ff   <= 2'd1;
         unesc_ff <= 1'b0;
      end else if (csr_we) begin
         if (csr_index == REG_TAB_MODE) tab_ff <= csr_wdata;
         else if (csr_index == REG_UNESCAPE) unesc_ff <= csr_wdata[0];
      end
   end

   stok_front #(.LINE_BITS(LINE_BITS), .COLUMN_BITS(COLUMN_BITS)) u_front (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready),
      .char_byte(req_tdata), .end_of_input(req_tuser[0]), .expected_mask(req_tuser[5:1]),
      .tab_mode(tab_ff), .unescape(unesc_ff),
      .q_valid, .q_ready, .q_item,
      .q_line0(l0), .q_col0(c0), .q_line1(l1), .q_col1(c1)
   );

   stok_back #(.LINE_BITS(LINE_BITS), .COLUMN_BITS(COLUMN_BITS)) u_back (
      .clock, .reset,
      .q_valid, .q_ready, .q_item,
      .q_line0(l0), .q_col0(c0), .q_line1(l1), .q_col1(c1),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_res(ores), .out_line(oline), .out_col(ocol), .out_last(rsp_tlast)
   );

   // result beat packing
   assign packed_d  = DW'({ocol, oline, ores.err, ores.done, ores.val, ores.has});
   assign rsp_tdata = packed_d;
   assign rsp_tuser = ores.kind;
endmodule
